// ===== rtl/sgpa_pkg.sv =====
// shared constants and codes for the streaming graph partition assigner
// no dependencies; imported by the datapath and the checker
`default_nettype none

package sgpa_pkg;

  // fixed field widths of the streaming words
  localparam int ID_BITS        = 22;
  localparam int PART_BITS      = 2;
  localparam int LABEL_BITS     = 32;
  localparam int WEIGHT_BITS    = 32;
  localparam int OUT_SCORE_BITS = 48;
  localparam int SIZE_BITS      = 23;

  // register port
  localparam int DATA_BITS = 32;
  localparam int ADDR_BITS = 4;
  localparam int REG_BITS  = 2;

  typedef enum logic {
    OP_SEED     = 1'b0,
    OP_NEIGHBOR = 1'b1
  } op_t;

  typedef enum logic [REG_BITS-1:0] {
    REG_WEIGHT_ONE    = 2'd0,
    REG_WEIGHT_TWENTY = 2'd1,
    REG_WEIGHT_FIFTY  = 2'd2
  } reg_idx_t;

  // labels that take a programmed weight
  localparam logic signed [LABEL_BITS-1:0] LABEL_ONE    = 32'sd1;
  localparam logic signed [LABEL_BITS-1:0] LABEL_TWENTY = 32'sd20;
  localparam logic signed [LABEL_BITS-1:0] LABEL_FIFTY  = 32'sd50;

  localparam logic signed [WEIGHT_BITS-1:0] WEIGHT_ONE_RESET    = -32'sd1600000;
  localparam logic signed [WEIGHT_BITS-1:0] WEIGHT_TWENTY_RESET = 32'sd20000;
  localparam logic signed [WEIGHT_BITS-1:0] WEIGHT_FIFTY_RESET  = 32'sd10000;

  localparam logic [SIZE_BITS-1:0] SIZE_FULL = '1;

endpackage

`default_nettype wire

// ===== rtl/streaming_graph_partition_assign.sv =====
// top level of the streaming graph partition assigner
// depends on sgpa_pkg and sgpa_membership
`default_nettype none

// Greedy streaming partitioner. Every word is either a seed (places a vertex into a
// given partition) or one neighbor of the vertex being placed; the neighbor's edge
// label picks a weight (labels 1, 20 and 50 take the programmed weights, any other
// label is its own weight) that is added to the score of the partition holding the
// neighbor. On the word marked last the vertex goes to the highest score, ties to
// the partition with more vertices and then to the lower index, and one result word
// comes out. A seed whose partition is out of range is dropped with no result.
// Throughput is one word per clock while in_stall is low. Besides the sweep and
// a full, stalled output, the hold-off is a read-after-write interlock on the
// membership memory: a neighbor that is the vertex of a placement still in the
// three stages up to the memory write (S1 to S3) waits. A result passes S1 to S4
// into the output register; the output register plus four pipeline stages keep
// taking words while a result waits. After reset the membership memory is swept
// clean, one entry per cycle, over all VERTICES entries (4194304 by default);
// in_stall stays high during the sweep, register writes are accepted throughout.
// Pipeline: accept (membership read of the neighbor) -> S1 score update ->
// S2 pairwise score compare -> S3 winner pick, size update, membership write
// (second read port supplies the vertex's old partition) -> S4 running total ->
// output register.

module streaming_graph_partition_assign #(
  parameter int PARTITIONS = 4,
  parameter int VERTICES   = 4194304,
  parameter int SCORE_BITS = 48
) (
  input  logic                                         clk,
  input  logic                                         rst,
  // register port
  input  logic                                         psel,
  input  logic                                         penable,
  input  logic                                         pwrite,
  input  logic [sgpa_pkg::ADDR_BITS-1:0]               paddr,
  input  logic [sgpa_pkg::DATA_BITS-1:0]               pwdata,
  output logic [sgpa_pkg::DATA_BITS-1:0]               prdata,
  output logic                                         pready,
  // input words
  input  logic                                         in_valid,
  output logic                                         in_stall,
  input  logic                                         operation,
  input  logic [sgpa_pkg::ID_BITS-1:0]                 vertex,
  input  logic [sgpa_pkg::PART_BITS-1:0]               seed_partition,
  input  logic [sgpa_pkg::ID_BITS-1:0]                 neighbor,
  input  logic                                         neighbor_valid,
  input  logic signed [sgpa_pkg::LABEL_BITS-1:0]       edge_label,
  input  logic                                         last,
  // result words
  output logic                                         out_valid,
  input  logic                                         out_stall,
  output logic [sgpa_pkg::ID_BITS-1:0]                 placed_vertex,
  output logic [sgpa_pkg::PART_BITS-1:0]               chosen_partition,
  output logic signed [sgpa_pkg::OUT_SCORE_BITS-1:0]   gained_weight,
  output logic [sgpa_pkg::SIZE_BITS-1:0]               partition_size,
  output logic signed [sgpa_pkg::OUT_SCORE_BITS-1:0]   partition_total
);

  import sgpa_pkg::*;

  localparam int SB  = SCORE_BITS;
  localparam int SBX = SCORE_BITS + 1;
  localparam int PW  = $clog2(PARTITIONS);
  localparam int MW  = $clog2(PARTITIONS + 1);   // membership code: 0 = unassigned
  localparam int AW  = $clog2(VERTICES);

  localparam logic signed [SB-1:0] SCORE_MAX = {1'b0, {(SB-1){1'b1}}};
  localparam logic signed [SB-1:0] SCORE_MIN = {1'b1, {(SB-1){1'b0}}};

  function automatic logic signed [SB-1:0] sat_add(input logic signed [SB-1:0] a,
                                                   input logic signed [SB-1:0] b);
    logic signed [SB:0] s;
    s = SBX'(a) + SBX'(b);
    if (s[SB] != s[SB-1]) begin
      sat_add = s[SB] ? SCORE_MIN : SCORE_MAX;
    end else begin
      sat_add = s[SB-1:0];
    end
  endfunction

  // ---------------------------------------------------------------------------
  // weight registers
  // ---------------------------------------------------------------------------
  logic signed [WEIGHT_BITS-1:0] weight_one;
  logic signed [WEIGHT_BITS-1:0] weight_twenty;
  logic signed [WEIGHT_BITS-1:0] weight_fifty;
  logic                          cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      weight_one    <= WEIGHT_ONE_RESET;
      weight_twenty <= WEIGHT_TWENTY_RESET;
      weight_fifty  <= WEIGHT_FIFTY_RESET;
    end else if (cfg_wr) begin
      case (paddr[ADDR_BITS-1:2])
        REG_WEIGHT_ONE:    weight_one    <= $signed(pwdata);
        REG_WEIGHT_TWENTY: weight_twenty <= $signed(pwdata);
        REG_WEIGHT_FIFTY:  weight_fifty  <= $signed(pwdata);
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[ADDR_BITS-1:2])
      REG_WEIGHT_ONE:    prdata = $unsigned(weight_one);
      REG_WEIGHT_TWENTY: prdata = $unsigned(weight_twenty);
      REG_WEIGHT_FIFTY:  prdata = $unsigned(weight_fifty);
      default:           prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // pipeline registers
  // ---------------------------------------------------------------------------
  // S1: neighbor membership arrives from the memory
  logic                          s1_valid;
  logic                          s1_seed;
  logic                          s1_last;
  logic                          s1_nb_ok;
  logic [ID_BITS-1:0]            s1_v;
  logic                          s1_v_in;
  logic [PW-1:0]                 s1_part;
  logic signed [WEIGHT_BITS-1:0] s1_weight;

  // S2: placing words only, with the score snapshot
  logic                          s2_valid;
  logic                          s2_seed;
  logic [ID_BITS-1:0]            s2_v;
  logic                          s2_v_in;
  logic [PW-1:0]                 s2_part;
  logic signed [SB-1:0]          s2_scores [PARTITIONS];

  // S3: pairwise compares ready, old membership arrives
  logic                                   s3_valid;
  logic                                   s3_seed;
  logic [ID_BITS-1:0]                     s3_v;
  logic                                   s3_v_in;
  logic [PW-1:0]                          s3_part;
  logic signed [SB-1:0]                   s3_scores [PARTITIONS];
  logic [PARTITIONS-1:0][PARTITIONS-1:0]  s3_gt;
  logic [PARTITIONS-1:0][PARTITIONS-1:0]  s3_eq;

  // S4: placement decided, running total pending
  logic                          s4_valid;
  logic [ID_BITS-1:0]            s4_v;
  logic                          s4_v_in;
  logic [PW-1:0]                 s4_part;
  logic [MW-1:0]                 s4_code;
  logic signed [SB-1:0]          s4_gained;
  logic [SIZE_BITS-1:0]          s4_size;

  // partition state
  logic signed [SB-1:0]          scores [PARTITIONS];
  logic [SIZE_BITS-1:0]          sizes [PARTITIONS];
  logic signed [SB-1:0]          totals [PARTITIONS];

  // memory interface
  logic                          mem_busy;
  logic [AW-1:0]                 rd_a_addr;
  logic [MW-1:0]                 rd_a_data;
  logic [AW-1:0]                 rd_b_addr;
  logic [MW-1:0]                 rd_b_data;
  logic                          wr_en;
  logic [AW-1:0]                 wr_addr;
  logic [MW-1:0]                 wr_data;

  // whole pipeline moves together; it only freezes when a result sits in S4
  // and the output register is full and stalled
  logic adv;
  assign adv = !(s4_valid && out_valid && out_stall);

  // ---------------------------------------------------------------------------
  // accept stage
  // ---------------------------------------------------------------------------
  logic                          is_seed;
  logic                          seed_ok;
  logic                          nb_in_range;
  logic                          v_in_range;
  logic                          nb_use;
  logic                          hazard;
  logic                          accept;
  logic signed [WEIGHT_BITS-1:0] weight_sel;

  assign is_seed     = (operation == OP_SEED);
  assign seed_ok     = int'(seed_partition) < PARTITIONS;
  assign nb_in_range = int'(neighbor) < VERTICES;
  assign v_in_range  = int'(vertex) < VERTICES;
  assign nb_use      = !is_seed && neighbor_valid && nb_in_range;

  // read-after-write interlock: the neighbor's membership may still be
  // waiting for its write in S3
  assign hazard = nb_use &&
                  ((s1_valid && (s1_seed || s1_last) && s1_v_in && s1_v == neighbor) ||
                   (s2_valid && s2_v_in && s2_v == neighbor) ||
                   (s3_valid && s3_v_in && s3_v == neighbor));

  assign in_stall = mem_busy || !adv || hazard;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    if (edge_label == LABEL_ONE) begin
      weight_sel = weight_one;
    end else if (edge_label == LABEL_TWENTY) begin
      weight_sel = weight_twenty;
    end else if (edge_label == LABEL_FIFTY) begin
      weight_sel = weight_fifty;
    end else begin
      weight_sel = edge_label;
    end
  end

  assign rd_a_addr = nb_in_range ? AW'(neighbor) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (adv) begin
      // out-of-range seeds never enter the pipe
      s1_valid <= accept && (!is_seed || seed_ok);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_seed   <= is_seed;
      s1_last   <= last;
      s1_nb_ok  <= neighbor_valid && nb_in_range;
      s1_v      <= vertex;
      s1_v_in   <= v_in_range;
      s1_part   <= PW'(seed_partition);
      s1_weight <= weight_sel;
    end
  end

  // ---------------------------------------------------------------------------
  // S1: score accumulate
  // ---------------------------------------------------------------------------
  logic signed [SB-1:0] scores_next [PARTITIONS];

  always_comb begin
    for (int i = 0; i < PARTITIONS; i++) begin
      scores_next[i] = scores[i];
      if (s1_valid && !s1_seed && s1_nb_ok && rd_a_data == MW'(i + 1)) begin
        scores_next[i] = sat_add(scores[i], SB'(s1_weight));
      end
    end
  end

  // a last word hands its scores to S2 and starts the next vertex from zero;
  // seeds leave the running scores alone
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < PARTITIONS; i++) begin
        scores[i] <= '0;
      end
    end else if (adv && s1_valid && !s1_seed) begin
      for (int i = 0; i < PARTITIONS; i++) begin
        scores[i] <= s1_last ? '0 : scores_next[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (adv) begin
      s2_valid <= s1_valid && (s1_seed || s1_last);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_seed <= s1_seed;
      s2_v    <= s1_v;
      s2_v_in <= s1_v_in;
      s2_part <= s1_part;
      for (int i = 0; i < PARTITIONS; i++) begin
        s2_scores[i] <= scores_next[i];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // S2: pairwise score compare
  // ---------------------------------------------------------------------------
  logic [PARTITIONS-1:0][PARTITIONS-1:0] cmp_gt;
  logic [PARTITIONS-1:0][PARTITIONS-1:0] cmp_eq;

  always_comb begin
    for (int i = 0; i < PARTITIONS; i++) begin
      for (int j = 0; j < PARTITIONS; j++) begin
        cmp_gt[i][j] = s2_scores[i] > s2_scores[j];
        cmp_eq[i][j] = s2_scores[i] == s2_scores[j];
      end
    end
  end

  // second read port fetches the vertex's current partition for S3
  assign rd_b_addr = s2_v_in ? AW'(s2_v) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else if (adv) begin
      s3_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s3_seed <= s2_seed;
      s3_v    <= s2_v;
      s3_v_in <= s2_v_in;
      s3_part <= s2_part;
      s3_gt   <= cmp_gt;
      s3_eq   <= cmp_eq;
      for (int i = 0; i < PARTITIONS; i++) begin
        s3_scores[i] <= s2_scores[i];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // S3: winner, sizes, membership write
  // ---------------------------------------------------------------------------
  logic [PARTITIONS-1:0] win;
  logic [PW-1:0]         win_part;
  logic [MW-1:0]         win_code;
  logic [MW-1:0]         old_code;
  logic signed [SB-1:0]  win_gained;
  logic [SIZE_BITS-1:0]  win_size;
  logic [SIZE_BITS-1:0]  sizes_next [PARTITIONS];

  // winner beats every other partition on (score, size), ties to lower index
  always_comb begin
    logic beat_all;
    win = '0;
    for (int i = 0; i < PARTITIONS; i++) begin
      beat_all = 1'b1;
      for (int j = 0; j < PARTITIONS; j++) begin
        if (j != i) begin
          beat_all = beat_all &&
                     (s3_gt[i][j] ||
                      (s3_eq[i][j] && (sizes[i] > sizes[j] ||
                                       (sizes[i] == sizes[j] && i < j))));
        end
      end
      win[i] = beat_all;
    end
    if (s3_seed) begin
      win = '0;
      win[s3_part] = 1'b1;
    end
  end

  // the word just ahead wrote its membership at the edge this read was taken
  assign old_code = (s4_valid && s4_v_in && s3_v_in && s4_v == s3_v) ? s4_code : rd_b_data;

  always_comb begin
    win_part   = '0;
    win_gained = '0;
    win_size   = '0;
    for (int i = 0; i < PARTITIONS; i++) begin
      sizes_next[i] = sizes[i];
      // a moved vertex leaves its old partition first
      if (s3_valid && s3_v_in && old_code == MW'(i + 1) && sizes_next[i] != '0) begin
        sizes_next[i] = sizes_next[i] - 1'b1;
      end
      if (s3_valid && win[i] && sizes_next[i] != SIZE_FULL) begin
        sizes_next[i] = sizes_next[i] + 1'b1;
      end
      if (win[i]) begin
        win_part = win_part | PW'(i);
        win_size = win_size | sizes_next[i];
        if (!s3_seed) begin
          win_gained = win_gained | s3_scores[i];
        end
      end
    end
  end

  assign win_code = MW'(win_part) + MW'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < PARTITIONS; i++) begin
        sizes[i] <= '0;
      end
    end else if (adv) begin
      for (int i = 0; i < PARTITIONS; i++) begin
        sizes[i] <= sizes_next[i];
      end
    end
  end

  assign wr_en   = adv && s3_valid && s3_v_in;
  assign wr_addr = AW'(s3_v);
  assign wr_data = win_code;

  always_ff @(posedge clk) begin
    if (rst) begin
      s4_valid <= 1'b0;
    end else if (adv) begin
      s4_valid <= s3_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s4_v      <= s3_v;
      s4_v_in   <= s3_v_in;
      s4_part   <= win_part;
      s4_code   <= win_code;
      s4_gained <= win_gained;
      s4_size   <= win_size;
    end
  end

  // ---------------------------------------------------------------------------
  // S4: running total and output register
  // ---------------------------------------------------------------------------
  logic signed [SB-1:0] total_next;

  assign total_next = sat_add(totals[s4_part], s4_gained);

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < PARTITIONS; i++) begin
        totals[i] <= '0;
      end
    end else if (adv && s4_valid) begin
      totals[s4_part] <= total_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv && s4_valid) begin
      out_valid <= 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && s4_valid) begin
      placed_vertex    <= s4_v;
      chosen_partition <= PART_BITS'(s4_part);
      gained_weight    <= OUT_SCORE_BITS'(s4_gained);
      partition_size   <= s4_size;
      partition_total  <= OUT_SCORE_BITS'(total_next);
    end
  end

  // ---------------------------------------------------------------------------
  // membership memory
  // ---------------------------------------------------------------------------
  sgpa_membership #(
    .DEPTH (VERTICES),
    .WIDTH (MW)
  ) u_membership (
    .clk       (clk),
    .rst       (rst),
    .rd_a_en   (accept),
    .rd_a_addr (rd_a_addr),
    .rd_a_data (rd_a_data),
    .rd_b_en   (adv),
    .rd_b_addr (rd_b_addr),
    .rd_b_data (rd_b_data),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .busy      (mem_busy)
  );

endmodule

`default_nettype wire

// ===== rtl/sgpa_membership.sv =====
// vertex membership store: two registered read ports, one write port
// clears itself after reset, one entry per cycle; no package needed
`default_nettype none

module sgpa_membership #(
  parameter int DEPTH = 4194304,
  parameter int WIDTH = 3
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       rd_a_en,
  input  logic [$clog2(DEPTH)-1:0]   rd_a_addr,
  output logic [WIDTH-1:0]           rd_a_data,
  input  logic                       rd_b_en,
  input  logic [$clog2(DEPTH)-1:0]   rd_b_addr,
  output logic [WIDTH-1:0]           rd_b_data,
  input  logic                       wr_en,
  input  logic [$clog2(DEPTH)-1:0]   wr_addr,
  input  logic [WIDTH-1:0]           wr_data,
  output logic                       busy
);

  localparam int AW = $clog2(DEPTH);

  typedef enum logic [1:0] {
    ST_CLEAR = 2'b01,
    ST_RUN   = 2'b10
  } clr_state_t;

  clr_state_t       state;
  logic [AW-1:0]    clr_addr;
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      clr_addr <= '0;
    end else begin
      case (state)
        ST_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == AW'(DEPTH - 1)) begin
            state <= ST_RUN;
          end
        end
        ST_RUN: begin
          clr_addr <= '0;
        end
        default: begin
          state <= ST_CLEAR;
        end
      endcase
    end
  end

  assign busy = (state != ST_RUN);

  // clearing sweep owns the write port while it runs
  always_ff @(posedge clk) begin
    if (state == ST_CLEAR) begin
      mem[clr_addr] <= '0;
    end else if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_a_en) begin
      rd_a_data <= mem[rd_a_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rd_b_en) begin
      rd_b_data <= mem[rd_b_addr];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/sgpa_checker.sv =====
// port-level checks for the streaming graph partition assigner, bound to the top level
// depends on sgpa_pkg
`default_nettype none

module sgpa_checker (
  input logic                                        clk,
  input logic                                        rst,
  input logic                                        psel,
  input logic                                        penable,
  input logic                                        pwrite,
  input logic [sgpa_pkg::ADDR_BITS-1:0]              paddr,
  input logic [sgpa_pkg::DATA_BITS-1:0]              pwdata,
  input logic [sgpa_pkg::DATA_BITS-1:0]              prdata,
  input logic                                        pready,
  input logic                                        in_stall,
  input logic                                        out_valid,
  input logic                                        out_stall,
  input logic [sgpa_pkg::ID_BITS-1:0]                placed_vertex,
  input logic [sgpa_pkg::PART_BITS-1:0]              chosen_partition,
  input logic signed [sgpa_pkg::OUT_SCORE_BITS-1:0]  gained_weight,
  input logic [sgpa_pkg::SIZE_BITS-1:0]              partition_size,
  input logic signed [sgpa_pkg::OUT_SCORE_BITS-1:0]  partition_total
);

  import sgpa_pkg::*;

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(placed_vertex) &&
      $stable(chosen_partition) && $stable(gained_weight) &&
      $stable(partition_size) && $stable(partition_total))
    else $error("result word changed while stalled");

  // membership sweep keeps input closed right after reset
  a_sweep_after_reset: assert property (@(posedge clk)
    rst |=> in_stall)
    else $error("input open right after reset");

  // a written weight reads back on the next cycle
  a_cfg_readback: assert property (@(posedge clk) disable iff (rst)
    (psel && penable && pwrite && pready &&
     (paddr[ADDR_BITS-1:2] == REG_WEIGHT_ONE ||
      paddr[ADDR_BITS-1:2] == REG_WEIGHT_TWENTY ||
      paddr[ADDR_BITS-1:2] == REG_WEIGHT_FIFTY))
    ##1 (paddr == $past(paddr)) |-> prdata == $past(pwdata))
    else $error("weight register readback mismatch");

endmodule

bind streaming_graph_partition_assign sgpa_checker u_sgpa_checker (.*);

`default_nettype wire
